// ===== hdl/psu_pkg.sv =====
package psu_pkg;

	localparam int NUM_PARTICLES   = 32;
	localparam int IDX_W           = $clog2(NUM_PARTICLES);
	localparam int SINC_TABLE_SIZE = 1024;
	localparam int SINC_AW         = $clog2(SINC_TABLE_SIZE);
	// A coordinate magnitude of 2^23 maps onto the full table span.
	localparam int SINC_SHIFT      = 23 - SINC_AW;

	localparam logic [63:0] Q28_ONE = 64'd268435456;
	localparam logic [63:0] Q28_PI  = 64'd843314857;

	typedef logic signed [23:0] pos_t;
	typedef logic signed [17:0] sinc_word_t;
	typedef sinc_word_t sinc_rom_t [SINC_TABLE_SIZE];

	typedef enum logic [0:0] {
		OP_LOAD   = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		CFG_ACCEL_GLOBAL   = 3'd0,
		CFG_ACCEL_PERSONAL = 3'd1,
		CFG_INERTIA_WEIGHT = 3'd2,
		CFG_TIME_STEP      = 3'd3,
		CFG_SEARCH_BOUND   = 3'd4
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MOVE,
		ST_LOOK,
		ST_SCORE,
		ST_FIT,
		ST_GMUL,
		ST_GRND,
		ST_PMUL,
		ST_PRND,
		ST_VEL
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [4:0]  particle_index;
		pos_t        load_pos_x;
		pos_t        load_pos_y;
		pos_t        load_vel_x;
		pos_t        load_vel_y;
		logic [15:0] rand_global_x;
		logic [15:0] rand_personal_x;
		logic [15:0] rand_global_y;
		logic [15:0] rand_personal_y;
	} item_t;

	typedef struct packed {
		logic [4:0] echo_index;
		pos_t       current_fitness;
		logic       personal_improved;
		logic       global_improved;
		pos_t       best_x;
		pos_t       best_y;
		pos_t       best_fitness;
	} result_t;

	// One particle's whole state, held as a single memory word.
	typedef struct packed {
		pos_t pos_x;
		pos_t pos_y;
		pos_t vel_x;
		pos_t vel_y;
		pos_t pb_x;
		pos_t pb_y;
		pos_t pb_fit;
	} entry_t;

	localparam logic [7:0] SINC_DIVS [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

	// Rounds to nearest with halves away from zero.
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
			input int unsigned sh);
		logic signed [63:0] half;
		half = 64'sd1 <<< (sh - 1);
		if (v >= 0) begin
			return (v + half) >>> sh;
		end
		return -((-v + half) >>> sh);
	endfunction

	function automatic pos_t sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end
		if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	// Unsigned long division by compare and subtract; it is only evaluated while
	// the sinc table is built, so it costs no logic.
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q, rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= d) begin
				rem  = rem - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry i holds sinc(i*128/SIZE) in signed Q1.16, from a Taylor series in Q28.
	function automatic sinc_rom_t build_sinc();
		sinc_rom_t   rom;
		logic [63:0] t, r, r2, acc, s, q;
		logic        neg;
		rom[0] = 18'sd65536;
		for (int i = 1; i < SINC_TABLE_SIZE; i++) begin
			t   = div_u64(64'(i) << 35, 64'(SINC_TABLE_SIZE));
			r   = t - div_u64(t, Q28_PI << 1) * (Q28_PI << 1);
			neg = 1'b0;
			if (r >= Q28_PI) begin
				r   = r - Q28_PI;
				neg = 1'b1;
			end
			if (r > (Q28_PI >> 1)) begin
				r = Q28_PI - r;
			end
			r2  = (r * r) >> 28;
			acc = Q28_ONE;
			for (int k = 0; k < 6; k++) begin
				acc = Q28_ONE - div_u64((r2 * acc) >> 28, 64'(SINC_DIVS[k]));
			end
			s = (r * acc) >> 28;
			q = div_u64((s << 16) + (t >> 1), t);
			rom[i] = neg ? -18'(q) : 18'(q);
		end
		return rom;
	endfunction

	localparam sinc_rom_t SINC_ROM = build_sinc();

endpackage

// ===== hdl/psu_ram.sv =====
module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hdl/psu_sinc_rom.sv =====
module psu_sinc_rom (
	input  logic                clk,
	input  logic                en,
	input  psu_pkg::pos_t       coord_x,
	input  psu_pkg::pos_t       coord_y,
	output psu_pkg::sinc_word_t sinc_x,
	output psu_pkg::sinc_word_t sinc_y
);
	import psu_pkg::*;

	logic [SINC_AW-1:0] addr_x, addr_y;

	// Nearest entry for |v|, clamped to the last entry.
	function automatic logic [SINC_AW-1:0] lookup_addr(input pos_t v);
		logic [23:0]            mag;
		logic [24-SINC_SHIFT:0] full;
		mag  = v[23] ? 24'(-v) : 24'(v);
		full = (25 - SINC_SHIFT)'((25'(mag) + 25'(1 << (SINC_SHIFT - 1))) >> SINC_SHIFT);
		if (full >= (25 - SINC_SHIFT)'(SINC_TABLE_SIZE)) begin
			return SINC_AW'(SINC_TABLE_SIZE - 1);
		end
		return full[SINC_AW-1:0];
	endfunction

	assign addr_x = lookup_addr(coord_x);
	assign addr_y = lookup_addr(coord_y);

	always_ff @(posedge clk) begin
		if (en) begin
			sinc_x <= SINC_ROM[addr_x];
			sinc_y <= SINC_ROM[addr_y];
		end
	end
endmodule

// ===== hdl/particle_swarm_update.sv =====
// Channel   Direction  Handshake                        Payload
// item      in         start high while busy is low     item   (psu_pkg::item_t)
// result    out        done high for one cycle          result (psu_pkg::result_t)
// config    in         write_enable, no wait            reg_index, write_data
//
// A load item passes through the look, score and fit states before the done strobe; an
// update item also goes through the one read-modify-write pass of the particle memory
// and the chain of multiply and rounding steps that the velocity terms go through.
// Reset sets the global best to zero and the registers to their defaults; the particle
// memory is not cleared. The receiver cannot stall, so a result never waits.
module particle_swarm_update (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  psu_pkg::item_t   item,
	output logic             done,
	output psu_pkg::result_t result,
	input  logic             write_enable,
	input  logic [2:0]       reg_index,
	input  logic [22:0]      write_data
);
	import psu_pkg::*;

	state_t state_q, state_next;

	logic [19:0] accel_global_q, accel_personal_q, time_step_q;
	logic [16:0] inertia_weight_q;
	logic [22:0] search_bound_q;

	item_t   item_q;
	entry_t  ent, wentry;
	pos_t    px_q, py_q, pbx_q, pby_q, pbfit_q;
	pos_t    gbest_x_q, gbest_y_q, gbest_fit_q;
	logic    inb_q;
	logic signed [35:0] sprod_q;
	logic signed [45:0] gmx_q, gmy_q, pmx_q, pmy_q;
	logic signed [29:0] tgx_q, tgy_q, tpx_q, tpy_q;
	result_t result_q;
	logic    done_q;

	sinc_word_t sinc_x, sinc_y;
	logic    accept, mem_re, mem_we, rom_en;
	pos_t    cur_fit, vel_x_new, vel_y_new;
	logic    pimp, gimp;

	assign accept = start && !busy;

	// Configuration writes are taken at once; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_global_q   <= 20'd134349;
			accel_personal_q <= 20'd134349;
			inertia_weight_q <= 17'd47776;
			time_step_q      <= 20'd65536;
			search_bound_q   <= 23'd655360;
		end else if (write_enable) begin
			case (reg_index)
				CFG_ACCEL_GLOBAL:   accel_global_q   <= write_data[19:0];
				CFG_ACCEL_PERSONAL: accel_personal_q <= write_data[19:0];
				CFG_INERTIA_WEIGHT: inertia_weight_q <= write_data[16:0];
				CFG_TIME_STEP:      time_step_q      <= write_data[19:0];
				CFG_SEARCH_BOUND:   search_bound_q   <= write_data;
				default: ;
			endcase
		end
	end

	// Sequencer: a load skips the memory read, the move and the velocity steps.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = (item.operation == OP_UPDATE) ? ST_FETCH : ST_LOOK;
				end
			end
			ST_FETCH: state_next = ST_MOVE;
			ST_MOVE:  state_next = ST_LOOK;
			ST_LOOK:  state_next = ST_SCORE;
			ST_SCORE: state_next = ST_FIT;
			ST_FIT:   state_next = (item_q.operation == OP_UPDATE) ? ST_GMUL : ST_IDLE;
			ST_GMUL:  state_next = ST_GRND;
			ST_GRND:  state_next = ST_PMUL;
			ST_PMUL:  state_next = ST_PRND;
			ST_PRND:  state_next = ST_VEL;
			ST_VEL:   state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != ST_IDLE);
		mem_re = accept && (item.operation == OP_UPDATE);
		rom_en = (state_q == ST_LOOK);
		mem_we = ((state_q == ST_FIT) && (item_q.operation == OP_LOAD)) || (state_q == ST_VEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			done_q  <= mem_we;
		end
	end

	// The memory is read only when an update is taken, so its output holds the
	// particle for the whole pass.
	psu_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_PARTICLES)
	) u_state_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(item_q.particle_index[IDX_W-1:0]),
		.wdata(wentry),
		.re   (mem_re),
		.raddr(item.particle_index[IDX_W-1:0]),
		.rdata(ent)
	);

	psu_sinc_rom u_sinc_rom (
		.clk    (clk),
		.en     (rom_en),
		.coord_x(px_q),
		.coord_y(py_q),
		.sinc_x (sinc_x),
		.sinc_y (sinc_y)
	);

	// Score: ten times the product of the two sinc values, zero outside the bound.
	always_comb begin
		logic signed [63:0] p64;
		p64     = 64'(sprod_q);
		cur_fit = inb_q ? 24'(round_shift((p64 <<< 3) + (p64 <<< 1), 16)) : '0;
		pimp    = (item_q.operation == OP_UPDATE) && (cur_fit > ent.pb_fit);
		gimp    = pimp && (cur_fit > gbest_fit_q);
	end

	always_comb begin
		logic signed [30:0] sum_x, sum_y;
		logic signed [48:0] wx, wy;
		sum_x = 31'(ent.vel_x) + 31'(tgx_q) + 31'(tpx_q);
		sum_y = 31'(ent.vel_y) + 31'(tgy_q) + 31'(tpy_q);
		wx    = sum_x * $signed({1'b0, inertia_weight_q});
		wy    = sum_y * $signed({1'b0, inertia_weight_q});
		vel_x_new = sat24(round_shift(64'(wx), 16));
		vel_y_new = sat24(round_shift(64'(wy), 16));
	end

	always_comb begin
		wentry.pos_x = px_q;
		wentry.pos_y = py_q;
		if (item_q.operation == OP_LOAD) begin
			wentry.vel_x  = item_q.load_vel_x;
			wentry.vel_y  = item_q.load_vel_y;
			wentry.pb_x   = px_q;
			wentry.pb_y   = py_q;
			wentry.pb_fit = cur_fit;
		end else begin
			wentry.vel_x  = vel_x_new;
			wentry.vel_y  = vel_y_new;
			wentry.pb_x   = pbx_q;
			wentry.pb_y   = pby_q;
			wentry.pb_fit = pbfit_q;
		end
	end

	// Datapath registers, one group per step of the sequencer.
	always_ff @(posedge clk) begin
		logic signed [44:0] mvx, mvy;
		logic signed [62:0] rx, ry;
		mvx = ent.vel_x * $signed({1'b0, time_step_q});
		mvy = ent.vel_y * $signed({1'b0, time_step_q});
		if (accept) begin
			item_q <= item;
			px_q   <= item.load_pos_x;
			py_q   <= item.load_pos_y;
		end
		case (state_q)
			ST_MOVE: begin
				px_q <= sat24(64'(ent.pos_x) + round_shift(64'(mvx), 16));
				py_q <= sat24(64'(ent.pos_y) + round_shift(64'(mvy), 16));
			end
			ST_LOOK: begin
				inb_q <= (25'(px_q) <= $signed({2'b0, search_bound_q}))
					&& (25'(px_q) >= -$signed({2'b0, search_bound_q}))
					&& (25'(py_q) <= $signed({2'b0, search_bound_q}))
					&& (25'(py_q) >= -$signed({2'b0, search_bound_q}));
			end
			ST_SCORE: sprod_q <= sinc_x * sinc_y;
			ST_FIT: begin
				pbx_q   <= pimp ? px_q : ent.pb_x;
				pby_q   <= pimp ? py_q : ent.pb_y;
				pbfit_q <= pimp ? cur_fit : ent.pb_fit;
			end
			ST_GMUL: begin
				gmx_q <= (25'(gbest_x_q) - 25'(px_q)) * $signed({1'b0, accel_global_q});
				gmy_q <= (25'(gbest_y_q) - 25'(py_q)) * $signed({1'b0, accel_global_q});
			end
			ST_GRND: begin
				rx = gmx_q * $signed({1'b0, item_q.rand_global_x});
				ry = gmy_q * $signed({1'b0, item_q.rand_global_y});
				tgx_q <= 30'(round_shift(64'(rx), 32));
				tgy_q <= 30'(round_shift(64'(ry), 32));
			end
			ST_PMUL: begin
				pmx_q <= (25'(pbx_q) - 25'(px_q)) * $signed({1'b0, accel_personal_q});
				pmy_q <= (25'(pby_q) - 25'(py_q)) * $signed({1'b0, accel_personal_q});
			end
			ST_PRND: begin
				rx = pmx_q * $signed({1'b0, item_q.rand_personal_x});
				ry = pmy_q * $signed({1'b0, item_q.rand_personal_y});
				tpx_q <= 30'(round_shift(64'(rx), 32));
				tpy_q <= 30'(round_shift(64'(ry), 32));
			end
			default: ;
		endcase
	end

	// Global best: a load clears only the score, an update replaces all three
	// when the new score beats both bests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbest_x_q   <= '0;
			gbest_y_q   <= '0;
			gbest_fit_q <= '0;
		end else if (state_q == ST_FIT) begin
			if (item_q.operation == OP_LOAD) begin
				gbest_fit_q <= '0;
			end else if (gimp) begin
				gbest_x_q   <= px_q;
				gbest_y_q   <= py_q;
				gbest_fit_q <= cur_fit;
			end
		end
	end

	// The result is settled once the score is known; the strobe follows the write.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIT) begin
			result_q.echo_index        <= item_q.particle_index;
			result_q.current_fitness   <= cur_fit;
			result_q.personal_improved <= pimp;
			result_q.global_improved   <= gimp;
			result_q.best_x            <= gimp ? px_q : gbest_x_q;
			result_q.best_y            <= gimp ? py_q : gbest_y_q;
			result_q.best_fitness      <= (item_q.operation == OP_LOAD) ? '0 :
				(gimp ? cur_fit : gbest_fit_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while a pass is running");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer did not start a pass");
	a_nested_best: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.personal_improved || !result.global_improved))
		else $error("global best improved without personal best");
	a_best_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.global_improved) |-> (result.best_fitness == result.current_fitness))
		else $error("global best score differs from new score");
`endif
endmodule

// ===== test/particle_swarm_update_tb.sv =====
`timescale 1ns / 100ps

module particle_swarm_update_tb;
	import psu_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        write_enable;
	logic [2:0]  reg_index;
	logic [22:0] write_data;

	particle_swarm_update dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.done         (done),
		.result       (result),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data)
	);

	// One row of the directed table. Where typed is set, the expected result is
	// written out by hand; otherwise it comes from the swarm predictor.
	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} row_t;

	// The testbench's own copy of the swarm: sinc table, particle state,
	// global best and the five registers.
	int     sinc_tab [SINC_TABLE_SIZE];
	longint pos_x [NUM_PARTICLES], pos_y [NUM_PARTICLES];
	longint vel_x [NUM_PARTICLES], vel_y [NUM_PARTICLES];
	longint pb_x [NUM_PARTICLES], pb_y [NUM_PARTICLES], pb_fit [NUM_PARTICLES];
	bit     loaded [NUM_PARTICLES];
	longint glob_x, glob_y, glob_fit;
	longint k_glob, k_pers, k_inert, k_step, k_bound;

	result_t expected_q [$];
	int      errors;
	int      results_seen;
	int      loads_sent;
	int      updates_sent;
	bit      burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Halves are rounded away from zero, as the block does.
	function automatic longint rnd_half(longint v, int sh);
		longint half;
		half = longint'(1) <<< (sh - 1);
		if (v >= 0) begin
			return (v + half) >>> sh;
		end
		return -((-v + half) >>> sh);
	endfunction

	function automatic longint clip24(longint v);
		if (v > 8388607) begin
			return 8388607;
		end
		if (v < -8388608) begin
			return -8388608;
		end
		return v;
	endfunction

	// Table entry i holds sinc(i*128/SIZE) in signed Q1.16. The sine comes from a Taylor
	// series evaluated in Q28 after folding the angle into the first quadrant.
	function automatic void fill_sinc_tab();
		longint unsigned one_q28, pi_q28, t, r, r2, acc, s, q;
		int unsigned     dv [6];
		bit              neg;
		one_q28 = 64'd268435456;
		pi_q28  = 64'd843314857;
		dv      = '{156, 110, 72, 42, 20, 6};
		sinc_tab[0] = 65536;
		for (int i = 1; i < SINC_TABLE_SIZE; i++) begin
			t   = (longint'(i) << 35) / SINC_TABLE_SIZE;
			r   = t % (2 * pi_q28);
			neg = 1'b0;
			if (r >= pi_q28) begin
				r   = r - pi_q28;
				neg = 1'b1;
			end
			if (r > pi_q28 / 2) begin
				r = pi_q28 - r;
			end
			r2  = (r * r) >> 28;
			acc = one_q28;
			for (int k = 0; k < 6; k++) begin
				acc = one_q28 - ((r2 * acc) >> 28) / dv[k];
			end
			s = (r * acc) >> 28;
			q = ((s << 16) + t / 2) / t;
			sinc_tab[i] = neg ? -int'(q) : int'(q);
		end
	endfunction

	function automatic longint sinc_of(longint v);
		longint mag, idx;
		mag = (v < 0) ? -v : v;
		idx = (mag * SINC_TABLE_SIZE + (longint'(1) << 22)) >>> 23;
		if (idx >= SINC_TABLE_SIZE) begin
			idx = SINC_TABLE_SIZE - 1;
		end
		return sinc_tab[idx];
	endfunction

	// Fitness is 10*sinc(x)*sinc(y); a coordinate on the bound itself still counts
	// as inside.
	function automatic longint fitness_at(longint px, longint py);
		if (px > k_bound || px < -k_bound || py > k_bound || py < -k_bound) begin
			return 0;
		end
		return rnd_half(sinc_of(px) * sinc_of(py) * 10, 16);
	endfunction

	function automatic longint steer(longint v, longint p, longint pb, longint g,
			longint rg, longint rp);
		longint tg, tp;
		tg = rnd_half((g - p) * k_glob * rg, 32);
		tp = rnd_half((pb - p) * k_pers * rp, 32);
		return clip24(rnd_half((v + tg + tp) * k_inert, 16));
	endfunction

	// Applies one transfer to the predicted swarm and returns the result it must give.
	function automatic result_t advance(item_t it);
		result_t r;
		int      i;
		longint  cur, px, py;
		bit      pimp, gimp;
		i    = it.particle_index;
		pimp = 1'b0;
		gimp = 1'b0;
		if (it.operation == OP_LOAD) begin
			pos_x[i] = it.load_pos_x;
			pos_y[i] = it.load_pos_y;
			vel_x[i] = it.load_vel_x;
			vel_y[i] = it.load_vel_y;
			cur = fitness_at(pos_x[i], pos_y[i]);
			pb_x[i]   = pos_x[i];
			pb_y[i]   = pos_y[i];
			pb_fit[i] = cur;
			loaded[i] = 1'b1;
			// Loading clears the global score but keeps its position.
			glob_fit = 0;
		end else begin
			px = clip24(pos_x[i] + rnd_half(vel_x[i] * k_step, 16));
			py = clip24(pos_y[i] + rnd_half(vel_y[i] * k_step, 16));
			pos_x[i] = px;
			pos_y[i] = py;
			cur = fitness_at(px, py);
			// The global best is only looked at when the personal best improved.
			if (cur > pb_fit[i]) begin
				pimp      = 1'b1;
				pb_fit[i] = cur;
				pb_x[i]   = px;
				pb_y[i]   = py;
				if (cur > glob_fit) begin
					gimp     = 1'b1;
					glob_fit = cur;
					glob_x   = px;
					glob_y   = py;
				end
			end
			vel_x[i] = steer(vel_x[i], px, pb_x[i], glob_x, it.rand_global_x,
				it.rand_personal_x);
			vel_y[i] = steer(vel_y[i], py, pb_y[i], glob_y, it.rand_global_y,
				it.rand_personal_y);
		end
		r.echo_index        = it.particle_index;
		r.current_fitness   = pos_t'(cur);
		r.personal_improved = pimp;
		r.global_improved   = gimp;
		r.best_x            = pos_t'(glob_x);
		r.best_y            = pos_t'(glob_y);
		r.best_fitness      = pos_t'(glob_fit);
		return r;
	endfunction

	function automatic item_t load_item(int idx, longint px, longint py, longint vx,
			longint vy);
		item_t it;
		it            = '0;
		it.operation  = OP_LOAD;
		it.particle_index = 5'(idx);
		it.load_pos_x = pos_t'(px);
		it.load_pos_y = pos_t'(py);
		it.load_vel_x = pos_t'(vx);
		it.load_vel_y = pos_t'(vy);
		it.rand_global_x   = 16'($urandom);
		it.rand_personal_y = 16'($urandom);
		return it;
	endfunction

	function automatic item_t update_item(int idx, int rgx, int rpx, int rgy, int rpy);
		item_t it;
		it                 = '0;
		it.operation       = OP_UPDATE;
		it.particle_index  = 5'(idx);
		it.load_pos_x      = pos_t'($urandom);
		it.load_vel_y      = pos_t'($urandom);
		it.rand_global_x   = 16'(rgx);
		it.rand_personal_x = 16'(rpx);
		it.rand_global_y   = 16'(rgy);
		it.rand_personal_y = 16'(rpy);
		return it;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Results cannot be held off, so every done strobe is checked at once.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result for particle %0d with none outstanding", $time,
					result.echo_index);
			end else begin
				want = expected_q.pop_front();
				if (result.echo_index !== want.echo_index)
					report_mismatch("echo_index", result.echo_index, want.echo_index);
				if (result.current_fitness !== want.current_fitness)
					report_mismatch("current_fitness", result.current_fitness,
						want.current_fitness);
				if (result.personal_improved !== want.personal_improved)
					report_mismatch("personal_improved", result.personal_improved,
						want.personal_improved);
				if (result.global_improved !== want.global_improved)
					report_mismatch("global_improved", result.global_improved,
						want.global_improved);
				if (result.best_x !== want.best_x)
					report_mismatch("best_x", result.best_x, want.best_x);
				if (result.best_y !== want.best_y)
					report_mismatch("best_y", result.best_y, want.best_y);
				if (result.best_fitness !== want.best_fitness)
					report_mismatch("best_fitness", result.best_fitness, want.best_fitness);
			end
		end
	end

	// Presents one item and holds it until the block takes it. Start is left high
	// afterwards so that a back-to-back item needs no second assignment.
	task automatic send(item_t it, bit typed, result_t want);
		result_t predicted;
		item  <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = advance(it);
		expected_q.push_back(typed ? want : predicted);
		if (it.operation == OP_LOAD) begin
			loads_sent++;
		end else begin
			updates_sent++;
		end
	endtask

	task automatic pause_sender();
		int gap;
		gap = burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits for every outstanding result, then lets the given number of extra edges
	// pass so that the block is truly idle. The wait runs up to a clock edge before it
	// looks at the queue, so the next transfer starts in a later time step.
	task automatic drain(int extra);
		start <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Drives one register write, waits on a clock edge and updates the model's copy; the
	// caller drops the write enable after the last write of a group.
	task automatic write_reg(cfg_index_t idx, logic [22:0] value);
		write_enable <= 1'b1;
		reg_index    <= idx;
		write_data   <= value;
		@(posedge clk);
		case (idx)
			CFG_ACCEL_GLOBAL:   k_glob  = value[19:0];
			CFG_ACCEL_PERSONAL: k_pers  = value[19:0];
			CFG_INERTIA_WEIGHT: k_inert = value[16:0];
			CFG_TIME_STEP:      k_step  = value[19:0];
			CFG_SEARCH_BOUND:   k_bound = value[22:0];
			default: ;
		endcase
	endtask

	task automatic write_all(int a, int p, int w, int t, int b);
		write_reg(CFG_ACCEL_GLOBAL, 23'(a));
		write_reg(CFG_ACCEL_PERSONAL, 23'(p));
		write_reg(CFG_INERTIA_WEIGHT, 23'(w));
		write_reg(CFG_TIME_STEP, 23'(t));
		write_reg(CFG_SEARCH_BOUND, 23'(b));
		write_enable <= 1'b0;
	endtask

	// A coordinate that lands inside or just past the bound most of the time, anywhere otherwise.
	function automatic longint rand_coord();
		if ($urandom_range(0, 3) != 0) begin
			return longint'($urandom_range(0, 2 * k_bound + 2)) - k_bound - 1;
		end
		return longint'(pos_t'($urandom));
	endfunction

	function automatic longint rand_speed();
		if ($urandom_range(0, 3) != 0) begin
			return longint'($urandom_range(0, 262144)) - 131072;
		end
		return longint'(pos_t'($urandom));
	endfunction

	initial begin
		row_t    rows [$];
		result_t none;
		item_t   it;
		int      idx;
		int      phases;
		none = '0;

		errors       = 0;
		results_seen = 0;
		loads_sent   = 0;
		updates_sent = 0;
		burst        = 1'b0;
		glob_x   = 0;
		glob_y   = 0;
		glob_fit = 0;
		k_glob   = 134349;
		k_pers   = 134349;
		k_inert  = 47776;
		k_step   = 65536;
		k_bound  = 655360;
		fill_sinc_tab();
		foreach (loaded[i]) loaded[i] = 1'b0;

		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		write_enable = 1'b0;
		reg_index    = CFG_ACCEL_GLOBAL;
		write_data   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part. The first loads follow reset directly, so the global best is
		// still at the origin with a cleared score: at the origin the score is a full
		// ten, and far outside the bound it is zero.
		rows.push_back('{load_item(0, 0, 0, 65536, -65536), 1'b1,
			'{echo_index: 5'd0, current_fitness: 24'sd655360, personal_improved: 1'b0,
			global_improved: 1'b0, best_x: 24'sd0, best_y: 24'sd0, best_fitness: 24'sd0}});
		rows.push_back('{load_item(1, 8388607, 8388607, 0, 0), 1'b1,
			'{echo_index: 5'd1, current_fitness: 24'sd0, personal_improved: 1'b0,
			global_improved: 1'b0, best_x: 24'sd0, best_y: 24'sd0, best_fitness: 24'sd0}});
		rows.push_back('{load_item(31, -8388608, -8388608, -1, 1), 1'b1,
			'{echo_index: 5'd31, current_fitness: 24'sd0, personal_improved: 1'b0,
			global_improved: 1'b0, best_x: 24'sd0, best_y: 24'sd0, best_fitness: 24'sd0}});
		// A coordinate exactly on the bound, on either side, is still scored.
		rows.push_back('{load_item(2, 655360, -655360, -200000, 200000), 1'b0, none});
		rows.push_back('{load_item(3, 100000, -30000, 8388607, -8388608), 1'b0, none});
		rows.push_back('{load_item(4, 300000, 250000, -40000, -50000), 1'b0, none});
		rows.push_back('{update_item(4, 0, 0, 0, 0), 1'b0, none});
		rows.push_back('{update_item(4, 65535, 65535, 65535, 65535), 1'b0, none});
		rows.push_back('{update_item(2, 30000, 40000, 50000, 60000), 1'b0, none});
		rows.push_back('{update_item(3, 65535, 0, 0, 65535), 1'b0, none});
		rows.push_back('{update_item(3, 12345, 23456, 34567, 45678), 1'b0, none});
		rows.push_back('{update_item(1, 65535, 65535, 65535, 65535), 1'b0, none});
		rows.push_back('{update_item(31, 0, 65535, 65535, 0), 1'b0, none});
		rows.push_back('{update_item(0, 20000, 20000, 20000, 20000), 1'b0, none});
		// A load between updates clears the global score, so the next update that
		// improves a personal best with a positive score takes the global best over.
		rows.push_back('{load_item(5, -5000, 7000, 90000, -90000), 1'b0, none});
		rows.push_back('{update_item(5, 40000, 40000, 40000, 40000), 1'b0, none});
		rows.push_back('{update_item(4, 1, 2, 3, 4), 1'b0, none});
		foreach (rows[n]) begin
			send(rows[n].it, rows[n].typed, rows[n].want);
			pause_sender();
		end
		drain(15);

		// Random part, in phases with a fresh register setting each time; the first
		// keeps the defaults, two others take the extremes.
		phases = 6;
		for (int ph = 0; ph < phases; ph++) begin
			case (ph)
				0: write_all(134349, 134349, 47776, 65536, 655360);
				1: write_all(0, 0, 0, 0, 0);
				2: write_all(1048575, 1048575, 131071, 1048575, 8388607);
				3: write_all(134349, 134349, 65536, 65536, 655360);
				default: write_all($urandom_range(0, 1048575), $urandom_range(0, 1048575),
					$urandom_range(0, 131071), $urandom_range(0, 1048575),
					$urandom_range(0, 8388607));
			endcase
			for (int n = 0; n < 300; n++) begin
				if (n % 40 == 0) begin
					burst = ($urandom_range(0, 3) == 0);
				end
				// At least once the sender holds back until everything is back.
				if (ph == 3 && n == 150) begin
					drain(0);
				end
				idx = $urandom_range(0, NUM_PARTICLES - 1);
				// A particle that was never loaded must not be updated.
				if (!loaded[idx] || $urandom_range(0, 99) < 15) begin
					it = load_item(idx, rand_coord(), rand_coord(), rand_speed(),
						rand_speed());
					it.rand_global_y   = 16'($urandom);
					it.rand_personal_x = 16'($urandom);
				end else begin
					it = update_item(idx, $urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535));
					it.load_pos_y = pos_t'($urandom);
					it.load_vel_x = pos_t'($urandom);
				end
				send(it, 1'b0, none);
				pause_sender();
			end
			drain(15);
		end

		$display("Covered %0d loads and %0d updates over %0d register settings;",
			loads_sent, updates_sent, phases);
		$display("%0d results checked against the swarm predictor.", results_seen);
		if (errors == 0) begin
			$display("** particle_swarm_update: PASSED **");
		end else begin
			$display("** particle_swarm_update: FAILED **");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timed out waiting for results.");
		$display("** particle_swarm_update: FAILED **");
		$finish;
	end

endmodule
